// ----- design/led_dimmer_ramp_unit_defines.svh -----
// Assertion macros shared by the LED dimmer checker.
`ifndef LED_DIMMER_RAMP_UNIT_DEFINES_SVH
`define LED_DIMMER_RAMP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ldr_pkg.sv -----
// Shared types and constants for the LED dimmer ramp unit.
package ldr_pkg;

  // Fixed-point and field widths
  localparam int FRAC_BITS_DEF = 16;
  localparam int PCT_W         = 7;
  localparam int RAMP_W        = 16;
  localparam int VAL_W         = 8;
  localparam int CFG_IDX_W     = 1;

  // Percent constants
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0] PCT_STEP   = 7'd10;
  localparam logic [PCT_W-1:0] PIN_THRESH = 7'd49;
  localparam logic [PCT_W-1:0] PRESET_RST = 7'd100;

  // Register reset values
  localparam logic [RAMP_W-1:0] RAMP_MS_RST = 16'd2000;
  localparam logic              PWM_RST     = 1'b1;

  // floor(q/100) = (q * 5243) >> 19 for q below 25600
  localparam int                 DUTY_Q_W    = 15;
  localparam logic [12:0]        DUTY_RECIP  = 13'd5243;
  localparam int                 DUTY_SHIFT  = 19;
  localparam int                 DUTY_PROD_W = 28;

  // Command codes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_LEVEL  = 3'd1,
    OP_ON         = 3'd2,
    OP_OFF        = 3'd3,
    OP_TOGGLE     = 3'd4,
    OP_BRIGHTER   = 3'd5,
    OP_DIMMER     = 3'd6,
    OP_SET_PRESET = 3'd7
  } ldr_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_MS     = 1'b0,
    CFG_PWM_CAPABLE = 1'b1
  } ldr_cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_cmd;
    logic exec;
    logic duty_calc;
    logic out_load;
  } ldr_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
  } ldr_stat_t;

endpackage

// ----- design/ldr_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module ldr_div #(
  parameter int DW = 23,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [DW-1:0] quo_r;
  logic          busy_r;
  logic          done_r;

  logic [VW:0]   rem_sh;
  logic [VW+1:0] trial;
  logic          ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = ~trial[VW+1];
  end

  // Control: busy and done flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Payload: remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? trial[VW-1:0] : rem_sh[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/ldr_ctrl.sv -----
// Command sequencer for the LED dimmer: accept, execute, divide, duty, output.
module ldr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ldr_pkg::ldr_ctrl_t ctrl,
  input  ldr_pkg::ldr_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DUTY,
    ST_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;
  logic   in_xfer;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Commands to the datapath
  always_comb begin
    ctrl.take_cmd  = in_xfer;
    ctrl.exec      = (state_r == ST_EXEC);
    ctrl.duty_calc = (state_r == ST_DUTY);
    ctrl.out_load  = (state_r == ST_OUT) && out_free;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads over the transfer of the old one
      if ((state_r == ST_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_tvalid && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          state_r <= stat.need_div ? ST_DIV : ST_DUTY;
        end
        ST_DIV: begin
          if (stat.div_done) state_r <= ST_DUTY;
        end
        ST_DUTY: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ldr_dp.sv -----
// Datapath for the LED dimmer: level, target, step, preset, duty and result.
module ldr_dp #(
  parameter int FRAC_BITS = ldr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ldr_pkg::ldr_ctrl_t             ctrl,
  output ldr_pkg::ldr_stat_t             stat,
  input  logic [2:0]                     opcode,
  input  logic [ldr_pkg::VAL_W-1:0]      level_value,
  input  logic                           cfg_we,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldr_pkg::RAMP_W-1:0]     cfg_data,
  output logic [7:0]                     duty,
  output logic                           pin_high,
  output logic [ldr_pkg::PCT_W-1:0]      level_percent,
  output logic [ldr_pkg::PCT_W-1:0]      target_percent,
  output logic                           is_on
);

  localparam int PW = ldr_pkg::PCT_W;
  localparam int LW = PW + FRAC_BITS;
  localparam int SW = LW + 1;

  // Configuration registers
  logic [ldr_pkg::RAMP_W-1:0] ramp_ms_r;
  logic                       pwm_r;

  // Architectural state
  logic [LW-1:0]        level_r;
  logic [PW-1:0]        target_r;
  logic signed [SW-1:0] step_r;
  logic [PW-1:0]        preset_r;

  // Command and working registers
  ldr_pkg::ldr_op_t          op_r;
  logic [PW-1:0]             val_r;
  logic                      neg_r;
  logic [ldr_pkg::DUTY_Q_W-1:0] q_r;

  // Result registers
  logic [7:0]    duty_r;
  logic          pin_r;
  logic [PW-1:0] lvl_pct_r;
  logic [PW-1:0] tgt_pct_r;
  logic          on_r;

  logic [PW-1:0]  pct;
  logic [PW:0]    bright_sum;
  logic           apply;
  logic           immediate;
  logic [LW-1:0]  pct_fix;
  logic [LW-1:0]  t_fix;
  logic [LW:0]    diff;
  logic [LW:0]    diff_abs;
  logic           need_div;
  logic           div_done;
  logic [LW-1:0]  quo;
  logic [SW-1:0]  quo_ext;
  logic signed [LW+1:0] sum_s;
  logic signed [LW+1:0] t_s;
  logic [LW-1:0]  tick_level;
  logic [LW+7:0]  l255;
  logic [ldr_pkg::DUTY_PROD_W-1:0] prod;

  // New target percent chosen by the command
  always_comb begin
    bright_sum = {1'b0, preset_r} + {1'b0, ldr_pkg::PCT_STEP};
    pct        = target_r;
    unique case (op_r)
      ldr_pkg::OP_TICK:       pct = target_r;
      ldr_pkg::OP_SET_LEVEL:  pct = val_r;
      ldr_pkg::OP_ON:         pct = ldr_pkg::PCT_MAX;
      ldr_pkg::OP_OFF:        pct = '0;
      ldr_pkg::OP_TOGGLE:     pct = (target_r == preset_r) ? '0 : preset_r;
      ldr_pkg::OP_BRIGHTER:
        pct = (bright_sum > {1'b0, ldr_pkg::PCT_MAX}) ? ldr_pkg::PCT_MAX : bright_sum[PW-1:0];
      ldr_pkg::OP_DIMMER:
        pct = (preset_r < ldr_pkg::PCT_STEP) ? '0 : preset_r - ldr_pkg::PCT_STEP;
      ldr_pkg::OP_SET_PRESET: pct = val_r;
      default:                pct = target_r;
    endcase
  end

  // Apply decision and fade delta
  always_comb begin
    apply     = (op_r != ldr_pkg::OP_TICK) && (pct != target_r) &&
                ((op_r != ldr_pkg::OP_SET_PRESET) || (val_r != preset_r));
    immediate = (ramp_ms_r == '0) || !pwm_r;
    pct_fix   = {pct, {FRAC_BITS{1'b0}}};
    t_fix     = {target_r, {FRAC_BITS{1'b0}}};
    need_div  = apply && !immediate && (level_r[LW-1:FRAC_BITS] != pct);
    diff      = {1'b0, pct_fix} - {1'b0, level_r};
    diff_abs  = diff[LW] ? (~diff + 1'b1) : diff;
  end

  // Tick: move by one step, clamped at the target
  always_comb begin
    sum_s = $signed({2'b00, level_r}) + $signed({step_r[SW-1], step_r});
    t_s   = $signed({2'b00, t_fix});
    if (!step_r[SW-1]) begin
      tick_level = (sum_s > t_s) ? t_fix : sum_s[LW-1:0];
    end else begin
      tick_level = (sum_s < t_s) ? t_fix : sum_s[LW-1:0];
    end
  end

  // Duty: level*255 >> FRAC_BITS, then divide by 100 via reciprocal
  always_comb begin
    l255 = {level_r, 8'b0} - {8'b0, level_r};
    prod = ldr_pkg::DUTY_PROD_W'(q_r) * ldr_pkg::DUTY_PROD_W'(ldr_pkg::DUTY_RECIP);
  end

  assign quo_ext = {1'b0, quo};

  ldr_div #(
    .DW (LW),
    .VW (ldr_pkg::RAMP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.exec && need_div),
    .dividend (diff_abs[LW-1:0]),
    .divisor  (ramp_ms_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    stat.need_div = need_div;
    stat.div_done = div_done;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_ms_r <= ldr_pkg::RAMP_MS_RST;
      pwm_r     <= ldr_pkg::PWM_RST;
    end else if (cfg_we) begin
      unique case (ldr_pkg::ldr_cfg_idx_t'(cfg_index))
        ldr_pkg::CFG_RAMP_MS:     ramp_ms_r <= cfg_data;
        ldr_pkg::CFG_PWM_CAPABLE: pwm_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Dimmer state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      step_r   <= '0;
      preset_r <= ldr_pkg::PRESET_RST;
    end else begin
      if (ctrl.exec) begin
        if (op_r == ldr_pkg::OP_TICK) begin
          if (level_r != t_fix) begin
            level_r <= (step_r == '0) ? t_fix : tick_level;
          end
        end else begin
          if ((op_r == ldr_pkg::OP_SET_PRESET) && (val_r != preset_r)) preset_r <= val_r;
          if (apply) begin
            target_r <= pct;
            if (immediate) level_r <= pct_fix;
          end
        end
      end
      if (div_done) step_r <= neg_r ? $signed(-quo_ext) : $signed(quo_ext);
    end
  end

  // Command latch and working registers
  always_ff @(posedge clk) begin
    if (ctrl.take_cmd) begin
      op_r  <= ldr_pkg::ldr_op_t'(opcode);
      val_r <= (level_value > {1'b0, ldr_pkg::PCT_MAX}) ? ldr_pkg::PCT_MAX
                                                        : level_value[PW-1:0];
    end
    if (ctrl.exec && need_div) neg_r <= diff[LW];
    if (ctrl.duty_calc) q_r <= l255[FRAC_BITS +: ldr_pkg::DUTY_Q_W];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      duty_r    <= prod[ldr_pkg::DUTY_SHIFT +: 8];
      pin_r     <= level_r > {ldr_pkg::PIN_THRESH, {FRAC_BITS{1'b0}}};
      lvl_pct_r <= level_r[LW-1:FRAC_BITS];
      tgt_pct_r <= target_r;
      on_r      <= (target_r != '0);
    end
  end

  assign duty           = duty_r;
  assign pin_high       = pin_r;
  assign level_percent  = lvl_pct_r;
  assign target_percent = tgt_pct_r;
  assign is_on          = on_r;

endmodule

// ----- design/led_dimmer_ramp_unit.sv -----
// LED dimmer with linear fade: takes one command per transfer and returns one status
// result for each. A tick or a command that needs no new fade step passes through the
// execute, duty and output states before the next input transfer; a command that
// starts a fade also goes through the bit-serial divider, which finds the per-tick step
// one quotient bit a cycle. The result sits in an output register, so a new command is
// taken while the previous result waits; the block stalls only when it has a second
// result ready and the first is still not taken. Configuration is always ready and
// must be written only while the unit is idle.
module led_dimmer_ramp_unit #(
  parameter int FRAC_BITS = ldr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: opcode[2:0], level_value[10:3], zero fill [15:11]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  // tdata: duty[7:0], pin_high[8], level_percent[15:9], target_percent[22:16], is_on[23]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ldr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldr_pkg::RAMP_W-1:0]    cfg_data
);

  ldr_pkg::ldr_ctrl_t ctrl;
  ldr_pkg::ldr_stat_t stat;

  logic [7:0]                duty;
  logic                      pin_high;
  logic [ldr_pkg::PCT_W-1:0] level_percent;
  logic [ldr_pkg::PCT_W-1:0] target_percent;
  logic                      is_on;

  assign cfg_ready = 1'b1;

  ldr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl),
    .stat       (stat)
  );

  ldr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .opcode         (in_tdata[2:0]),
    .level_value    (in_tdata[10:3]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .duty           (duty),
    .pin_high       (pin_high),
    .level_percent  (level_percent),
    .target_percent (target_percent),
    .is_on          (is_on)
  );

  assign out_tdata = {is_on, target_percent, level_percent, pin_high, duty};

endmodule

// ----- design/ldr_checker.sv -----
// Port-level checks for the LED dimmer, bound to the top level.
`include "led_dimmer_ramp_unit_defines.svh"

module ldr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result holds
  `LDR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // One command at a time: no input transfer right after one
  `LDR_ASSERT_NEXT(a_one_cmd, in_tvalid && in_tready, !in_tready, "input ready straight after a transfer")

  // is_on follows the target
  `LDR_ASSERT_NOW(a_is_on, out_tvalid, out_tdata[23] == (out_tdata[22:16] != 7'd0), "is_on disagrees with target")

  // Level and target stay within percent range
  `LDR_ASSERT_NOW(a_range, out_tvalid, (out_tdata[15:9] <= 7'd100) && (out_tdata[22:16] <= 7'd100), "percent out of range")

  // Pin drive consistent with the integer level; at 49 the fraction decides
  `LDR_ASSERT_NOW(a_pin, out_tvalid, out_tdata[8] ? (out_tdata[15:9] >= 7'd49) : (out_tdata[15:9] <= 7'd49), "pin drive disagrees with level")

endmodule

bind led_dimmer_ramp_unit ldr_checker u_ldr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/led_dimmer_ramp_unit_tb.sv -----
// Self-checking testbench for the LED dimmer ramp unit: directed and randomised commands against a fade model.
module led_dimmer_ramp_unit_tb;

  localparam int FRAC_W     = ldr_pkg::FRAC_BITS_DEF;
  localparam int LVL_W      = ldr_pkg::PCT_W + FRAC_W;
  localparam int STEP_W     = LVL_W + 1;
  localparam int PCT_FULL   = 100;
  localparam int PCT_INC    = 10;
  localparam int PIN_LIMIT  = 49;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_PHASES = 20;
  localparam int PHASE_ITEMS = 100;

  // One command as it travels on in_tdata, last field lowest
  typedef struct packed {
    logic [ldr_pkg::VAL_W-1:0] value;
    ldr_pkg::ldr_op_t          op;
  } dim_cmd_t;

  // One status result as it travels on out_tdata, last field lowest
  typedef struct packed {
    logic                      is_on;
    logic [ldr_pkg::PCT_W-1:0] target_pct;
    logic [ldr_pkg::PCT_W-1:0] level_pct;
    logic                      pin_high;
    logic [7:0]                duty;
  } dim_status_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [23:0]                   out_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ldr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ldr_pkg::RAMP_W-1:0]    cfg_data;

  dim_cmd_t    pending_cmds[$];
  dim_status_t expected_status[$];
  dim_cmd_t    cur_cmd;
  int          errors = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  bit          no_gaps = 1'b0;

  // Fade model state and its copy of the registers
  logic [LVL_W-1:0]           dim_level;
  logic [ldr_pkg::PCT_W-1:0]  dim_target;
  logic signed [STEP_W-1:0]   dim_step;
  logic [ldr_pkg::PCT_W-1:0]  dim_preset;
  logic [ldr_pkg::RAMP_W-1:0] dim_ramp_ms;
  logic                       dim_pwm;

  led_dimmer_ramp_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // opcode, level_value, zero fill
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // duty, pin_high, level_percent, target_percent, is_on
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [LVL_W-1:0] fixed_pct(input logic [ldr_pkg::PCT_W-1:0] pct);
    return LVL_W'(pct) << FRAC_W;
  endfunction

  function automatic void dimmer_reset();
    dim_level   = '0;
    dim_target  = '0;
    dim_step    = '0;
    dim_preset  = 7'(PCT_FULL);
    dim_ramp_ms = 16'd2000;
    dim_pwm     = 1'b1;
  endfunction

  // New target: jump at once or work out the per-tick step
  function automatic void dimmer_apply(input logic [ldr_pkg::PCT_W-1:0] pct);
    int delta;
    int mag;
    if (pct == dim_target) return;
    dim_target = pct;
    if (dim_ramp_ms == 0 || !dim_pwm) begin
      dim_level = fixed_pct(pct);
      return;
    end
    if (dim_level[LVL_W-1:FRAC_W] != dim_target) begin
      delta = int'(fixed_pct(dim_target)) - int'(dim_level);
      mag = (delta < 0 ? -delta : delta) / int'(dim_ramp_ms);
      dim_step = STEP_W'(delta < 0 ? -mag : mag);
    end
  endfunction

  // One millisecond: move by the step, never past the target
  function automatic void dimmer_tick();
    int goal;
    int nxt;
    goal = int'(fixed_pct(dim_target));
    if (int'(dim_level) == goal) return;
    if (dim_step == 0) begin
      dim_level = LVL_W'(goal);
      return;
    end
    nxt = int'(dim_level) + int'(dim_step);
    if (dim_step > 0) begin
      if (nxt > goal) nxt = goal;
    end else if (nxt < goal) begin
      nxt = goal;
    end
    dim_level = LVL_W'(nxt);
  endfunction

  function automatic dim_status_t dimmer_predict(input dim_cmd_t cmd);
    logic [ldr_pkg::PCT_W-1:0] v;
    dim_status_t               r;
    longint                    lv;
    v = (cmd.value > PCT_FULL) ? 7'(PCT_FULL) : cmd.value[ldr_pkg::PCT_W-1:0];
    case (cmd.op)
      ldr_pkg::OP_TICK:      dimmer_tick();
      ldr_pkg::OP_SET_LEVEL: dimmer_apply(v);
      ldr_pkg::OP_ON:        dimmer_apply(7'(PCT_FULL));
      ldr_pkg::OP_OFF:       dimmer_apply(7'd0);
      ldr_pkg::OP_TOGGLE:    dimmer_apply(dim_target == dim_preset ? 7'd0 : dim_preset);
      ldr_pkg::OP_BRIGHTER:
        dimmer_apply((int'(dim_preset) + PCT_INC > PCT_FULL) ? 7'(PCT_FULL)
                                                             : 7'(dim_preset + PCT_INC));
      ldr_pkg::OP_DIMMER:
        dimmer_apply((int'(dim_preset) < PCT_INC) ? 7'd0 : 7'(dim_preset - PCT_INC));
      ldr_pkg::OP_SET_PRESET: begin
        if (v != dim_preset) begin
          dim_preset = v;
          dimmer_apply(v);
        end
      end
      default: ;
    endcase
    lv           = longint'(dim_level);
    r.duty       = 8'((lv * 255) / (longint'(PCT_FULL) << FRAC_W));
    r.pin_high   = dim_level > fixed_pct(7'(PIN_LIMIT));
    r.level_pct  = dim_level[LVL_W-1:FRAC_W];
    r.target_pct = dim_target;
    r.is_on      = dim_target != 7'd0;
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ldr_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd100;
      2:       return 8'd255;
      3:       return 8'($urandom_range(101, 255));
      default: return 8'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic void push_cmd(input ldr_pkg::ldr_op_t op,
                                   input logic [ldr_pkg::VAL_W-1:0] value);
    dim_cmd_t c;
    c.op    = op;
    c.value = value;
    pending_cmds.push_back(c);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Sender: one command per transfer, predicted as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_status.push_back(dimmer_predict(cur_cmd));
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_tdata  <= {5'd0, cur_cmd};
          in_tvalid <= 1'b1;
          tx_gap    <= no_gaps ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest prediction
  always @(posedge clk) begin
    dim_status_t want;
    dim_status_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
      hold_ack   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = dim_status_t'(out_tdata);
        if (expected_status.size() == 0) begin
          $error("result with no command outstanding: out_tdata %h", out_tdata);
          errors++;
        end else begin
          want = expected_status.pop_front();
          check_field("duty", int'(want.duty), int'(got.duty));
          check_field("pin_high", int'(want.pin_high), int'(got.pin_high));
          check_field("level_percent", int'(want.level_pct), int'(got.level_pct));
          check_field("target_percent", int'(want.target_pct), int'(got.target_pct));
          check_field("is_on", int'(want.is_on), int'(got.is_on));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_ack != hold_req) begin
        hold_ack   <= hold_req;
        rx_stall   <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall   <= rx_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall   <= no_gaps ? 0 : pick_gap();
      end
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input ldr_pkg::ldr_cfg_idx_t idx,
                           input logic [ldr_pkg::RAMP_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ldr_pkg::CFG_RAMP_MS) dim_ramp_ms = data;
    else dim_pwm = data[0];
  endtask

  task automatic set_config(input logic [ldr_pkg::RAMP_W-1:0] ramp, input logic pwm);
    wait_idle();
    write_reg(ldr_pkg::CFG_RAMP_MS, ramp);
    write_reg(ldr_pkg::CFG_PWM_CAPABLE, {15'(0), pwm});
  endtask

  // Stimulus
  initial begin
    int ramp;
    int sent;
    int n;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ldr_pkg::CFG_RAMP_MS;
    cfg_data  = '0;
    dimmer_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every command at reset settings, saturation and preset edges
    push_cmd(ldr_pkg::OP_TICK, 8'd255);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd255);
    push_cmd(ldr_pkg::OP_TICK, 8'd0);
    push_cmd(ldr_pkg::OP_TICK, 8'd0);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd100);
    push_cmd(ldr_pkg::OP_OFF, 8'd0);
    push_cmd(ldr_pkg::OP_TICK, 8'd0);
    push_cmd(ldr_pkg::OP_ON, 8'd255);
    push_cmd(ldr_pkg::OP_TOGGLE, 8'd0);
    push_cmd(ldr_pkg::OP_TOGGLE, 8'd0);
    push_cmd(ldr_pkg::OP_SET_PRESET, 8'd0);
    push_cmd(ldr_pkg::OP_BRIGHTER, 8'd0);
    push_cmd(ldr_pkg::OP_DIMMER, 8'd0);
    push_cmd(ldr_pkg::OP_SET_PRESET, 8'd0);
    push_cmd(ldr_pkg::OP_SET_PRESET, 8'd200);
    push_cmd(ldr_pkg::OP_BRIGHTER, 8'd0);
    push_cmd(ldr_pkg::OP_DIMMER, 8'd0);
    push_cmd(ldr_pkg::OP_TOGGLE, 8'd0);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd0);

    // On/off pin: immediate changes
    set_config(16'hFFFF, 1'b0);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd5);
    push_cmd(ldr_pkg::OP_OFF, 8'd0);

    // Slowest fade: a step too small to represent makes the tick jump
    set_config(16'hFFFF, 1'b1);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd100);
    push_cmd(ldr_pkg::OP_TICK, 8'd0);
    push_cmd(ldr_pkg::OP_SET_LEVEL, 8'd1);
    push_cmd(ldr_pkg::OP_TICK, 8'd0);

    // Random phases, each with its own settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0:       ramp = (ph < 10) ? 0 : 1;
        1:       ramp = $urandom_range(1, 8);
        2:       ramp = $urandom_range(9, 60);
        3:       ramp = (ph < 10) ? 65535 : 2000;
        default: ramp = $urandom_range(0, 65535);
      endcase
      set_config(16'(ramp), (ph % 7 == 2) ? 1'b0 : 1'b1);
      no_gaps = (ph == 3) || (ph % 6 == 5);
      if (ph == 3) hold_req++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          // a command followed by ticks that carry the fade along
          push_cmd(ldr_pkg::ldr_op_t'($urandom_range(1, 7)), rand_value());
          n = $urandom_range(0, (ramp < 40) ? ramp + 3 : 40);
          repeat (n) push_cmd(ldr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
          sent += n + 1;
        end else begin
          push_cmd(ldr_pkg::ldr_op_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      errors++;
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ldr_pkg.sv
design/ldr_div.sv
design/ldr_ctrl.sv
design/ldr_dp.sv
design/led_dimmer_ramp_unit.sv
design/ldr_checker.sv
test/led_dimmer_ramp_unit_tb.sv
